@@ rtl/assert_macros.svh @@
// Assertion macros used by the output stage (sida_serial) of the decimal text converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge of i_clk outside reset.
`define SIDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge of i_clk outside reset.
`define SIDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sida_pkg.sv @@
// Types and constants shared by the decimal text converter modules.
`default_nettype none

package sida_pkg;

    localparam logic [6:0]  CHAR_ZERO  = 7'd48;
    localparam logic [6:0]  CHAR_MINUS = 7'd45;
    // Reciprocal of ten scaled by 2^19; exact quotient for every 16-bit operand.
    localparam logic [15:0] RECIP_TEN  = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    // One number in flight: sign, remaining magnitude and the digits found so far.
    // digits[0] is the units digit once all four divide stages have run.
    typedef struct packed {
        logic            neg;
        logic [15:0]     mag;
        logic [3:0][3:0] digits;
    } t_item;

endpackage

`default_nettype wire

@@ rtl/sida_digit.sv @@
// One pipeline stage that divides the magnitude by ten and records the remainder.
`default_nettype none

module sida_digit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  sida_pkg::t_item    i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output sida_pkg::t_item    o_item
);
    import sida_pkg::*;

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic [31:0] w_prod;
    logic [15:0] w_quot;
    logic [15:0] w_rem;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        w_prod = 32'(i_item.mag) * 32'(RECIP_TEN);
        w_quot = 16'(w_prod >> RECIP_SHIFT);
        w_rem  = i_item.mag - ((w_quot << 3) + (w_quot << 1));
        n_item        = i_item;
        n_item.mag    = w_quot;
        // New digit enters at the top; after four stages the units digit sits at index 0.
        n_item.digits = {w_rem[3:0], i_item.digits[3:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sida_serial.sv @@
// Output stage that sends the sign and the significant digits one character per request.
`default_nettype none

`include "assert_macros.svh"

module sida_serial (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  sida_pkg::t_item    i_item,
    output logic               o_tvalid,
    input  wire logic          i_tready,
    output logic [6:0]         o_tdata,   // character
    output logic               o_tlast
);
    import sida_pkg::*;

    logic            r_busy;
    logic            r_minus;
    logic [2:0]      r_idx;
    logic [4:0][3:0] r_digits;
    logic [4:0][3:0] n_digits;
    logic [2:0]      n_idx;
    logic            w_last;
    logic            w_fire;
    logic            w_load;
    logic [3:0]      w_digit;

    assign w_last   = !r_minus && (r_idx == 3'd0);
    assign w_fire   = r_busy && i_tready;
    assign o_ready  = !r_busy || (i_tready && w_last);
    assign w_load   = i_valid && o_ready;
    assign w_digit  = r_digits[r_idx];
    assign o_tvalid = r_busy;
    assign o_tdata  = r_minus ? CHAR_MINUS : (CHAR_ZERO + 7'(w_digit));
    assign o_tlast  = w_last;

    always_comb begin
        // After the last divide the remaining quotient is the top digit, below ten.
        n_digits = {i_item.mag[3:0], i_item.digits};
        if (n_digits[4] != 4'd0) begin
            n_idx = 3'd4;
        end else if (n_digits[3] != 4'd0) begin
            n_idx = 3'd3;
        end else if (n_digits[2] != 4'd0) begin
            n_idx = 3'd2;
        end else if (n_digits[1] != 4'd0) begin
            n_idx = 3'd1;
        end else begin
            n_idx = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_minus <= 1'b0;
            r_idx   <= 3'd0;
        end else if (w_load) begin
            r_busy  <= 1'b1;
            r_minus <= i_item.neg;
            r_idx   <= n_idx;
        end else if (w_fire) begin
            if (r_minus) begin
                r_minus <= 1'b0;
            end else if (r_idx == 3'd0) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_digits <= n_digits;
        end
    end

    `SIDA_ASSERT_NOW(a_load_when_free, w_load, !r_busy || (w_fire && w_last), "load over pending text")
    `SIDA_ASSERT_NOW(a_digit_range, r_busy && !r_minus, w_digit <= 4'd9, "digit out of range")
    `SIDA_ASSERT_NEXT(a_minus_then_digit, w_fire && r_minus, r_busy && !r_minus, "sign not followed by digit")

endmodule

`default_nettype wire

@@ rtl/signed_int_to_decimal_ascii.sv @@
// Top level: a signed 16-bit value in, its decimal ASCII text out one character per request.
// A value goes through a sign stage, four divide-by-ten stages (one 16x16 reciprocal
// multiply each) and an output stage, registered in that order, after which its
// characters are offered on the output. Characters leave at one per cycle while
// tready is high, most significant first, with a leading '-' for negative values and
// tlast on the final digit; a value therefore yields one to six characters, six for
// -10000 down to -32768, and the output port sets the sustained rate. The pipeline
// holds several values at once, and its occupied stages stall while the downstream
// side holds tready low.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // character, zero pad
    output logic             m_axis_tlast    // last_char
);
    import sida_pkg::*;

    localparam int NUM_DIV = 4;

    logic  r_s0_valid;
    t_item r_s0_item;
    t_item n_s0_item;

    logic  [NUM_DIV:0] w_valid;
    logic  [NUM_DIV:0] w_ready;
    t_item [NUM_DIV:0] w_item;

    logic [6:0] w_char;

    always_comb begin
        n_s0_item.neg    = s_axis_tdata[15];
        n_s0_item.mag    = s_axis_tdata[15] ? (~s_axis_tdata + 16'd1) : s_axis_tdata;
        n_s0_item.digits = '0;
    end

    assign s_axis_tready = !r_s0_valid || w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s0_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s0_item <= n_s0_item;
        end
    end

    assign w_valid[0] = r_s0_valid;
    assign w_item[0]  = r_s0_item;

    for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
        sida_digit u_digit (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_item  (w_item[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    sida_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[NUM_DIV]),
        .o_ready  (w_ready[NUM_DIV]),
        .i_item   (w_item[NUM_DIV]),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (w_char),
        .o_tlast  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_char};

endmodule

`default_nettype wire
